FILE: sv/ipv4lpm_pkg.sv
// ----------------------------------------------------------------------------
// ipv4lpm_pkg
// shared constants, types and helper functions of the ipv4 lpm forwarder
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4lpm_pkg;

  localparam int ROUTE_ENTRIES = 64;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int TTL_W  = 8;
  localparam int CSUM_W = 16;

  // longest prefix that can match a 32-bit address
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  // item function codes
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_FWD = 1'b1;

  typedef enum logic [2:0] {
    DEC_LOCAL    = 3'd0,
    DEC_FORWARD  = 3'd1,
    DEC_NO_ROUTE = 3'd2,
    DEC_EXPIRED  = 3'd3,
    DEC_ADDED    = 3'd4,
    DEC_FULL     = 3'd5
  } decision_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] hop;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  // control from the sequencer to the match unit
  typedef struct packed {
    logic clear;
    logic eval;
  } scan_ctl_t;

  // top len bits set; len of 32 or more gives all ones
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

  // incremental checksum update for a ttl decrement, end-around fold
  function automatic logic [CSUM_W-1:0] csum_dec(input logic [CSUM_W-1:0] csum);
    logic [CSUM_W:0]   sum;
    logic [CSUM_W-1:0] fold;
    sum  = {1'b0, ~csum} + {1'b0, 16'hfeff};
    fold = sum[CSUM_W-1:0] + CSUM_W'(sum[CSUM_W]);
    csum_dec = ~fold;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ipv4lpm_route_ram.sv
// ----------------------------------------------------------------------------
// ipv4lpm_route_ram
// simple dual-port route table memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4lpm_route_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 70,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/ipv4lpm_match.sv
// ----------------------------------------------------------------------------
// ipv4lpm_match
// compares one route entry per cycle and keeps the best match found so far
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4lpm_match (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire ipv4lpm_pkg::scan_ctl_t               ctl,
  input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]       dest,
  input  wire ipv4lpm_pkg::route_t                  entry,
  output logic                                      found,
  output logic      [ipv4lpm_pkg::ADDR_W-1:0]       best_hop
);

  logic                             found_r,    found_nxt;
  logic [ipv4lpm_pkg::LEN_W-1:0]    best_len_r, best_len_nxt;
  logic [ipv4lpm_pkg::ADDR_W-1:0]   best_hop_r, best_hop_nxt;
  logic                             hit;
  logic                             take;

  // prefix hit: length in range and the masked bits agree
  assign hit = (entry.length <= ipv4lpm_pkg::MAX_LEN) &&
               (((dest ^ entry.prefix) & ipv4lpm_pkg::prefix_mask(entry.length)) == '0);

  // equal length also wins so that the later entry replaces the earlier
  assign take = ctl.eval && hit && (entry.length >= best_len_r);

  always_comb begin
    found_nxt    = found_r;
    best_len_nxt = best_len_r;
    best_hop_nxt = best_hop_r;
    priority if (ctl.clear) begin
      found_nxt    = 1'b0;
      best_len_nxt = '0;
      best_hop_nxt = '0;
    end else if (take) begin
      found_nxt    = 1'b1;
      best_len_nxt = entry.length;
      best_hop_nxt = entry.hop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      best_len_r <= '0;
    end else begin
      found_r    <= found_nxt;
      best_len_r <= best_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_hop_r <= best_hop_nxt;
  end

  assign found    = found_r;
  assign best_hop = best_hop_r;

endmodule

`default_nettype wire

FILE: sv/ipv4_lpm_forwarder.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_forwarder
// route table with longest prefix match lookup and ttl / checksum rewrite
// ----------------------------------------------------------------------------
// usage
//   an item transfers on a rising edge with start high and busy low. in_func
//   selects adding a route (appended at the table end) or forwarding a header.
//   each item gives exactly one result: out_valid is high for one cycle with
//   decision, next hop, ttl and checksum on the out_ ports. the receiver has
//   no stall, so every strobe is a completed transfer.
//   local_address is written through cfg_valid / cfg_ready (always ready);
//   write it only while the block is idle.
// sequencing
//   add, local delivery and a lookup in an empty table: result in the cycle
//   after the transfer, and busy stays low, so these run one per cycle.
//   a lookup reads the route memory one entry per cycle over all stored
//   routes, then passes the drain and finish states before its result;
//   busy is high in between. the single memory read port sets this pace.
// reset
//   rst_n low clears the route count, the local address and the sequencer;
//   table contents are not cleared, entries past the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_lpm_forwarder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // command channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_func,
  input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]     in_address,
  input  wire logic [ipv4lpm_pkg::LEN_W-1:0]      in_mask_length,
  input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]     in_next_hop,
  input  wire logic [ipv4lpm_pkg::TTL_W-1:0]      in_ttl,
  input  wire logic [ipv4lpm_pkg::CSUM_W-1:0]     in_checksum,
  // result channel
  output logic                                    out_valid,
  output logic      [2:0]                         out_decision,
  output logic      [ipv4lpm_pkg::ADDR_W-1:0]     out_hop_out,
  output logic      [ipv4lpm_pkg::TTL_W-1:0]      out_ttl_out,
  output logic      [ipv4lpm_pkg::CSUM_W-1:0]     out_checksum_out,
  // configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]     cfg_local_address
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,  // issuing one table read per cycle
    S_DRAIN  = 4'b0100,  // last read data being compared
    S_FINISH = 4'b1000   // best match settled, build the result
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ipv4lpm_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                                rd_vld_r;
  logic [ipv4lpm_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [ipv4lpm_pkg::ADDR_W-1:0]      local_address_r;

  // header fields held during a lookup
  logic [ipv4lpm_pkg::ADDR_W-1:0]      dest_r, dest_nxt;
  logic [ipv4lpm_pkg::TTL_W-1:0]       ttl_r, ttl_nxt;
  logic [ipv4lpm_pkg::CSUM_W-1:0]      csum_r, csum_nxt;

  // result register
  logic                                out_valid_r, out_valid_nxt;
  ipv4lpm_pkg::decision_t              out_decision_r, out_decision_nxt;
  logic [ipv4lpm_pkg::ADDR_W-1:0]      out_hop_r, out_hop_nxt;
  logic [ipv4lpm_pkg::TTL_W-1:0]       out_ttl_r, out_ttl_nxt;
  logic [ipv4lpm_pkg::CSUM_W-1:0]      out_csum_r, out_csum_nxt;

  logic                                accept;
  logic                                table_full;
  logic                                last_read;
  logic                                wr_en;
  logic                                rd_en;
  ipv4lpm_pkg::route_t                 wr_entry;
  ipv4lpm_pkg::route_t                 rd_entry;
  ipv4lpm_pkg::scan_ctl_t              scan_ctl;
  logic                                match_found;
  logic [ipv4lpm_pkg::ADDR_W-1:0]      match_hop;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign table_full = (count_r == ipv4lpm_pkg::CNT_W'(ipv4lpm_pkg::ROUTE_ENTRIES));
  assign last_read  = ((ipv4lpm_pkg::CNT_W'(idx_r) + ipv4lpm_pkg::CNT_W'(1)) == count_r);

  // appends go only in idle, scans only read: no same-entry overlap
  assign wr_en           = accept && (in_func == ipv4lpm_pkg::FUNC_ADD) && !table_full;
  assign wr_entry.prefix = in_address;
  assign wr_entry.length = in_mask_length;
  assign wr_entry.hop    = in_next_hop;
  assign rd_en           = (state_r == S_SCAN);

  assign scan_ctl.clear = accept;
  assign scan_ctl.eval  = rd_vld_r;

  ipv4lpm_route_ram #(
    .DEPTH (ipv4lpm_pkg::ROUTE_ENTRIES),
    .WIDTH (ipv4lpm_pkg::ROUTE_W)
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ipv4lpm_pkg::IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_entry)
  );

  ipv4lpm_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .dest     (dest_r),
    .entry    (rd_entry),
    .found    (match_found),
    .best_hop (match_hop)
  );

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    count_nxt        = count_r;
    dest_nxt         = dest_r;
    ttl_nxt          = ttl_r;
    csum_nxt         = csum_r;
    out_valid_nxt    = 1'b0;
    out_decision_nxt = out_decision_r;
    out_hop_nxt      = out_hop_r;
    out_ttl_nxt      = out_ttl_r;
    out_csum_nxt     = out_csum_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // default result fields, overridden only by a forward
          out_hop_nxt  = '0;
          out_ttl_nxt  = in_ttl;
          out_csum_nxt = in_checksum;
          priority if (in_func == ipv4lpm_pkg::FUNC_ADD) begin
            out_valid_nxt = 1'b1;
            if (table_full) begin
              out_decision_nxt = ipv4lpm_pkg::DEC_FULL;
            end else begin
              out_decision_nxt = ipv4lpm_pkg::DEC_ADDED;
              count_nxt        = count_r + ipv4lpm_pkg::CNT_W'(1);
            end
          end else if (in_address == local_address_r) begin
            out_valid_nxt    = 1'b1;
            out_decision_nxt = ipv4lpm_pkg::DEC_LOCAL;
          end else if (count_r == '0) begin
            out_valid_nxt    = 1'b1;
            out_decision_nxt = ipv4lpm_pkg::DEC_NO_ROUTE;
          end else begin
            dest_nxt  = in_address;
            ttl_nxt   = in_ttl;
            csum_nxt  = in_checksum;
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last_read) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + ipv4lpm_pkg::IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        out_valid_nxt = 1'b1;
        out_ttl_nxt   = ttl_r;
        out_csum_nxt  = csum_r;
        out_hop_nxt   = '0;
        // no route takes precedence over an expired ttl
        priority if (!match_found) begin
          out_decision_nxt = ipv4lpm_pkg::DEC_NO_ROUTE;
        end else if (ttl_r == '0) begin
          out_decision_nxt = ipv4lpm_pkg::DEC_EXPIRED;
        end else begin
          out_decision_nxt = ipv4lpm_pkg::DEC_FORWARD;
          out_hop_nxt      = match_hop;
          out_ttl_nxt      = ttl_r - ipv4lpm_pkg::TTL_W'(1);
          out_csum_nxt     = ipv4lpm_pkg::csum_dec(csum_r);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      idx_r           <= '0;
      rd_vld_r        <= 1'b0;
      count_r         <= '0;
      local_address_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_en;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        local_address_r <= cfg_local_address;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dest_r         <= dest_nxt;
    ttl_r          <= ttl_nxt;
    csum_r         <= csum_nxt;
    out_decision_r <= out_decision_nxt;
    out_hop_r      <= out_hop_nxt;
    out_ttl_r      <= out_ttl_nxt;
    out_csum_r     <= out_csum_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_decision     = out_decision_r;
  assign out_hop_out      = out_hop_r;
  assign out_ttl_out      = out_ttl_r;
  assign out_checksum_out = out_csum_r;

  // a scan is only started with at least one stored route
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0))
    else $error("scan running over an empty table");

  // the route count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ipv4lpm_pkg::CNT_W'(ipv4lpm_pkg::ROUTE_ENTRIES))
    else $error("route count beyond table depth");

  // read data is compared only for reads issued during the scan
  a_read_source: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |=> ($past(state_r) == S_SCAN || $past(state_r) == S_DRAIN))
    else $error("compare without a scan read");

  // a result strobe follows either a transfer in idle or the finish step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(accept) || $past(state_r) == S_FINISH))
    else $error("result strobe without a cause");

  // the table is never appended while a lookup is in flight
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !wr_en)
    else $error("table write during lookup");

endmodule

`default_nettype wire

FILE: test/ipv4_lpm_forwarder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_lpm_forwarder_test
// self-checking bench for the route table and forwarding decision block
// ----------------------------------------------------------------------------
// a short table of hand-written items covers the corner cases: empty table,
// local delivery ahead of lookup, expired ttl, ties between equal lengths,
// default route and over-long prefixes. three random phases follow, with
// different sender gaps and local addresses. they fill the table to its
// limit and then keep adding into the full table. every result is checked
// field by field against a bench model of the table, or a typed row's decision.
// ----------------------------------------------------------------------------
module ipv4_lpm_forwarder_test;

  // cycles with no transfer of any kind before the run is declared hung
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 375;
  // longer than the longest lookup, so this covers a late stray result
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic                           func;
    logic [ipv4lpm_pkg::ADDR_W-1:0] address;
    logic [ipv4lpm_pkg::LEN_W-1:0]  mask_length;
    logic [ipv4lpm_pkg::ADDR_W-1:0] next_hop;
    logic [ipv4lpm_pkg::TTL_W-1:0]  ttl;
    logic [ipv4lpm_pkg::CSUM_W-1:0] checksum;
  } fwd_cmd_t;

  typedef struct {
    ipv4lpm_pkg::decision_t         decision;
    logic [ipv4lpm_pkg::ADDR_W-1:0] hop;
    logic [ipv4lpm_pkg::TTL_W-1:0]  ttl;
    logic [ipv4lpm_pkg::CSUM_W-1:0] checksum;
  } verdict_t;

  // directed row: typed rows carry their decision, the rest use the model
  typedef struct {
    fwd_cmd_t               cmd;
    bit                     typed;
    ipv4lpm_pkg::decision_t want;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n             = 1'b0;
  logic                           start             = 1'b0;
  logic                           busy;
  logic                           in_func           = 1'b0;
  logic [ipv4lpm_pkg::ADDR_W-1:0] in_address        = '0;
  logic [ipv4lpm_pkg::LEN_W-1:0]  in_mask_length    = '0;
  logic [ipv4lpm_pkg::ADDR_W-1:0] in_next_hop       = '0;
  logic [ipv4lpm_pkg::TTL_W-1:0]  in_ttl            = '0;
  logic [ipv4lpm_pkg::CSUM_W-1:0] in_checksum       = '0;
  logic                           out_valid;
  logic [2:0]                     out_decision;
  logic [ipv4lpm_pkg::ADDR_W-1:0] out_hop_out;
  logic [ipv4lpm_pkg::TTL_W-1:0]  out_ttl_out;
  logic [ipv4lpm_pkg::CSUM_W-1:0] out_checksum_out;
  logic                           cfg_valid         = 1'b0;
  logic                           cfg_ready;
  logic [ipv4lpm_pkg::ADDR_W-1:0] cfg_local_address = '0;

  // bench copy of the route table and the local address register
  logic [ipv4lpm_pkg::ADDR_W-1:0] rt_prefix [ipv4lpm_pkg::ROUTE_ENTRIES];
  logic [ipv4lpm_pkg::LEN_W-1:0]  rt_len    [ipv4lpm_pkg::ROUTE_ENTRIES];
  logic [ipv4lpm_pkg::ADDR_W-1:0] rt_hop    [ipv4lpm_pkg::ROUTE_ENTRIES];
  int                             rt_count         = 0;
  logic [ipv4lpm_pkg::ADDR_W-1:0] local_addr_model = '0;

  verdict_t  verdicts_due[$];
  plan_row_t directed_rows[$];

  int failures        = 0;
  int items_sent      = 0;
  int cfg_writes      = 0;
  int sender_idle_pct = 0;
  int decision_seen [8];

  ipv4_lpm_forwarder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_address        (in_address),
    .in_mask_length    (in_mask_length),
    .in_next_hop       (in_next_hop),
    .in_ttl            (in_ttl),
    .in_checksum       (in_checksum),
    .out_valid         (out_valid),
    .out_decision      (out_decision),
    .out_hop_out       (out_hop_out),
    .out_ttl_out       (out_ttl_out),
    .out_checksum_out  (out_checksum_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_local_address (cfg_local_address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // the model: applies one accepted item to the bench table and gives the
  // result the block has to produce for it
  function automatic verdict_t forwarding_verdict(input fwd_cmd_t c);
    verdict_t                       v;
    logic [ipv4lpm_pkg::ADDR_W-1:0] diff;
    logic [ipv4lpm_pkg::ADDR_W-1:0] best_hop;
    logic [ipv4lpm_pkg::CSUM_W-1:0] inv;
    int                             same;
    int                             best_len;
    bit                             found;
    int unsigned                    sum;
    v.decision = ipv4lpm_pkg::DEC_NO_ROUTE;
    v.hop      = '0;
    v.ttl      = c.ttl;
    v.checksum = c.checksum;
    found      = 1'b0;
    best_len   = 0;
    best_hop   = '0;
    if (c.func == ipv4lpm_pkg::FUNC_ADD) begin
      if (rt_count >= ipv4lpm_pkg::ROUTE_ENTRIES) begin
        v.decision = ipv4lpm_pkg::DEC_FULL;
      end else begin
        rt_prefix[rt_count] = c.address;
        rt_len[rt_count]    = c.mask_length;
        rt_hop[rt_count]    = c.next_hop;
        rt_count++;
        v.decision = ipv4lpm_pkg::DEC_ADDED;
      end
    end else if (c.address == local_addr_model) begin
      // own address wins over any route and any ttl
      v.decision = ipv4lpm_pkg::DEC_LOCAL;
    end else begin
      for (int i = 0; i < rt_count; i++) begin
        // count leading bits shared by destination and prefix
        diff = c.address ^ rt_prefix[i];
        same = 0;
        while (same < ipv4lpm_pkg::ADDR_W && !diff[ipv4lpm_pkg::ADDR_W-1-same]) same++;
        // >= on the length lets a later entry of equal length take over
        if (same >= int'(rt_len[i]) && int'(rt_len[i]) >= best_len) begin
          best_len = int'(rt_len[i]);
          best_hop = rt_hop[i];
          found    = 1'b1;
        end
      end
      if (!found) begin
        v.decision = ipv4lpm_pkg::DEC_NO_ROUTE;
      end else if (c.ttl == '0) begin
        v.decision = ipv4lpm_pkg::DEC_EXPIRED;
      end else begin
        // ones-complement add of 0xfeff, carry folded back once
        inv        = ~c.checksum;
        sum        = {16'h0, inv} + 32'h0000_feff;
        sum        = (sum & 32'h0000_ffff) + (sum >> 16);
        v.decision = ipv4lpm_pkg::DEC_FORWARD;
        v.hop      = best_hop;
        v.ttl      = c.ttl - 8'd1;
        v.checksum = ~sum[15:0];
      end
    end
    return v;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void plan_row(input logic func,
                                   input logic [ipv4lpm_pkg::ADDR_W-1:0] addr,
                                   input logic [ipv4lpm_pkg::LEN_W-1:0] len,
                                   input logic [ipv4lpm_pkg::ADDR_W-1:0] hop,
                                   input logic [ipv4lpm_pkg::TTL_W-1:0] ttl,
                                   input logic [ipv4lpm_pkg::CSUM_W-1:0] csum,
                                   input bit typed, input ipv4lpm_pkg::decision_t want);
    plan_row_t r;
    r.cmd.func        = func;
    r.cmd.address     = addr;
    r.cmd.mask_length = len;
    r.cmd.next_hop    = hop;
    r.cmd.ttl         = ttl;
    r.cmd.checksum    = csum;
    r.typed           = typed;
    r.want            = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // one command transfer; called at a rising edge, returns at the edge
  // where the transfer happened. start stays high for a back-to-back item
  task automatic send_item(input fwd_cmd_t c, input bit typed,
                           input ipv4lpm_pkg::decision_t want);
    verdict_t model_v;
    verdict_t typed_v;
    int       gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    // now and then a long gap, so the next start lands anywhere in a lookup
    if (sender_idle_pct != 0 && $urandom_range(99) < 5) gap += $urandom_range(70, 1);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= c.func;
    in_address     <= c.address;
    in_mask_length <= c.mask_length;
    in_next_hop    <= c.next_hop;
    in_ttl         <= c.ttl;
    in_checksum    <= c.checksum;
    do @(posedge clk); while (busy);
    model_v = forwarding_verdict(c);
    if (typed) begin
      // typed rows never forward, so hop is zero and ttl / checksum pass
      typed_v.decision = want;
      typed_v.hop      = '0;
      typed_v.ttl      = c.ttl;
      typed_v.checksum = c.checksum;
      verdicts_due.insert(verdicts_due.size(), typed_v);
    end else begin
      verdicts_due.insert(verdicts_due.size(), model_v);
    end
    items_sent++;
  endtask

  // sender holds off until every pending result is back and busy is low;
  // sampled on the falling edge, returns on a rising edge
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (verdicts_due.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_local_address(input logic [ipv4lpm_pkg::ADDR_W-1:0] value);
    cfg_valid         <= 1'b1;
    cfg_local_address <= value;
    do @(posedge clk); while (!cfg_ready);
    local_addr_model = value;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct);
    fwd_cmd_t                       c;
    logic [ipv4lpm_pkg::ADDR_W-1:0] keep;
    int                             pick;
    int                             route;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < n_items; k++) begin
      c.address     = $urandom;
      c.mask_length = ipv4lpm_pkg::LEN_W'($urandom);
      c.next_hop    = $urandom;
      c.ttl         = ipv4lpm_pkg::TTL_W'($urandom);
      c.checksum    = ipv4lpm_pkg::CSUM_W'($urandom);
      // adds are frequent until the table fills, then only probe the full case
      if ($urandom_range(99) < ((rt_count < ipv4lpm_pkg::ROUTE_ENTRIES) ? 20 : 6)) begin
        c.func = ipv4lpm_pkg::FUNC_ADD;
        pick = $urandom_range(99);
        if (pick < 4) c.mask_length = '0;
        else if (pick < 12) c.mask_length = ipv4lpm_pkg::LEN_W'($urandom_range(63, 33));
        else if (pick < 40) c.mask_length = ipv4lpm_pkg::LEN_W'(8 * $urandom_range(4, 1));
        else c.mask_length = ipv4lpm_pkg::LEN_W'($urandom_range(32, 1));
      end else begin
        c.func = ipv4lpm_pkg::FUNC_FWD;
        pick = $urandom_range(99);
        if (pick < 10) begin
          c.address = local_addr_model;
        end else if (pick < 65) begin
          // hit a stored prefix, random bits below its length
          route     = $urandom_range(rt_count - 1);
          keep      = ~({ipv4lpm_pkg::ADDR_W{1'b1}} >> rt_len[route]);
          c.address = (rt_prefix[route] & keep) | (c.address & ~keep);
        end
        pick = $urandom_range(99);
        if (pick < 10) c.ttl = '0;
        else if (pick < 16) c.ttl = 8'd1;
        else if (pick < 20) c.ttl = '1;
        pick = $urandom_range(99);
        if (pick < 4) c.checksum = '0;
        else if (pick < 8) c.checksum = '1;
        else if (pick < 11) c.checksum = 16'hfeff;
      end
      send_item(c, 1'b0, ipv4lpm_pkg::DEC_LOCAL);
      // occasional full drain in mid phase
      if ($urandom_range(199) == 0) wait_until_drained();
    end
  endtask

  // every strobe is a completed transfer; compare with the oldest expectation
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        note_failure($sformatf("result with nothing pending: dec=%0d hop=%h ttl=%h csum=%h",
                               out_decision, out_hop_out, out_ttl_out, out_checksum_out));
      end else begin
        want = verdicts_due.pop_front();
        decision_seen[want.decision]++;
        if (out_decision !== want.decision || out_hop_out !== want.hop ||
            out_ttl_out !== want.ttl || out_checksum_out !== want.checksum) begin
          note_failure($sformatf(
            "expected dec=%0d hop=%h ttl=%h csum=%h, got dec=%0d hop=%h ttl=%h csum=%h",
            want.decision, want.hop, want.ttl, want.checksum,
            out_decision, out_hop_out, out_ttl_out, out_checksum_out));
        end
      end
    end
  end

  // hang detection: any transfer on any channel restarts the count
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // local address 0: same as after reset, but written explicitly
    write_local_address('0);

    // directed part, with the local address at zero
    // empty table: own address delivers, anything else has no route
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0000_0000, 6'd0,  32'h0,         8'd64,  16'h1234,
             1, ipv4lpm_pkg::DEC_LOCAL);
    // no route is reported ahead of a zero ttl
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'hffff_ffff, 6'd63, 32'hffff_ffff, 8'd0,   16'h0000,
             1, ipv4lpm_pkg::DEC_NO_ROUTE);
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h0a00_0000, 6'd8,  32'h0a00_00fe, 8'd0,   16'hffff,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0a01_0203, 6'd0,  32'h0,         8'd64,  16'hb1e6,
             0, ipv4lpm_pkg::DEC_LOCAL);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0a01_0203, 6'd0,  32'h0,         8'd0,   16'h4321,
             1, ipv4lpm_pkg::DEC_EXPIRED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0b00_0001, 6'd0,  32'h0,         8'd9,   16'h0001,
             1, ipv4lpm_pkg::DEC_NO_ROUTE);
    // longer prefix beats the /8
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h0a01_0000, 6'd16, 32'h0a01_fffe, 8'd255, 16'h0000,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0a01_0203, 6'd0,  32'h0,         8'd1,   16'h0000,
             0, ipv4lpm_pkg::DEC_LOCAL);
    // equal length, later entry wins
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h0a01_0000, 6'd16, 32'h0a01_0001, 8'd3,   16'h7fff,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0a01_abcd, 6'd0,  32'h0,         8'd255, 16'hffff,
             0, ipv4lpm_pkg::DEC_LOCAL);
    // full length host route
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'hffff_ffff, 6'd32, 32'hffff_ffff, 8'd17,  16'h8000,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'hffff_ffff, 6'd0,  32'h0,         8'd255, 16'h0000,
             0, ipv4lpm_pkg::DEC_LOCAL);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'hffff_fffe, 6'd0,  32'h0,         8'd2,   16'h5555,
             1, ipv4lpm_pkg::DEC_NO_ROUTE);
    // length above 32 is stored but matches nothing
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h1234_5678, 6'd33, 32'h0000_0001, 8'd0,   16'haaaa,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h1234_5678, 6'd0,  32'h0,         8'd10,  16'h1111,
             1, ipv4lpm_pkg::DEC_NO_ROUTE);
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'hc0a8_0000, 6'd63, 32'h0000_0000, 8'd128, 16'h0f0f,
             1, ipv4lpm_pkg::DEC_ADDED);
    // default route catches the rest
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h0000_0000, 6'd0,  32'hdead_beef, 8'd1,   16'hf0f0,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h1234_5678, 6'd0,  32'h0,         8'd10,  16'h1111,
             0, ipv4lpm_pkg::DEC_LOCAL);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0a01_0203, 6'd0,  32'h0,         8'd10,  16'h2222,
             0, ipv4lpm_pkg::DEC_LOCAL);
    // second /8 after the default route takes over the first
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h0a00_0000, 6'd8,  32'h0a00_00fd, 8'd200, 16'h0100,
             1, ipv4lpm_pkg::DEC_ADDED);
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0a02_0000, 6'd0,  32'h0,         8'd128, 16'h8000,
             0, ipv4lpm_pkg::DEC_LOCAL);
    // own address even with ttl zero and a default route present
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h0000_0000, 6'd0,  32'h0,         8'd0,   16'h0000,
             1, ipv4lpm_pkg::DEC_LOCAL);
    plan_row(ipv4lpm_pkg::FUNC_ADD, 32'h8000_0000, 6'd32, 32'h8000_0001, 8'd5,   16'hfffe,
             1, ipv4lpm_pkg::DEC_ADDED);
    // checksum whose update wraps to zero
    plan_row(ipv4lpm_pkg::FUNC_FWD, 32'h8000_0000, 6'd0,  32'h0,         8'd1,   16'hfeff,
             0, ipv4lpm_pkg::DEC_LOCAL);

    sender_idle_pct = 8;
    foreach (directed_rows[r])
      send_item(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
    wait_until_drained();

    // random phases, each behind a fresh local address written while idle
    write_local_address('1);
    run_random_phase(PHASE_ITEMS, 8);
    wait_until_drained();

    write_local_address($urandom);
    run_random_phase(PHASE_ITEMS, 45);
    wait_until_drained();

    // local address on top of a stored prefix, so the two checks collide
    write_local_address(rt_prefix[$urandom_range(rt_count - 1)]);
    run_random_phase(PHASE_ITEMS, 0);
    wait_until_drained();

    // catch any stray result after the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0)
      note_failure($sformatf("%0d results never arrived", verdicts_due.size()));

    $display("covered %0d items, %0d local address writes, table filled to %0d routes",
             items_sent, cfg_writes, rt_count);
    $display("results: %0d local, %0d forwarded, %0d no route, %0d expired, %0d added, %0d full",
             decision_seen[ipv4lpm_pkg::DEC_LOCAL], decision_seen[ipv4lpm_pkg::DEC_FORWARD],
             decision_seen[ipv4lpm_pkg::DEC_NO_ROUTE], decision_seen[ipv4lpm_pkg::DEC_EXPIRED],
             decision_seen[ipv4lpm_pkg::DEC_ADDED], decision_seen[ipv4lpm_pkg::DEC_FULL]);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
